// ===== src/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

  // surrogate ranges and utf-8 marker bytes
  localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_LIM  = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM  = 16'h0800;
  localparam logic [10:0] PLANE_OFFSET  = 11'h040;  // 0x10000 >> 10
  localparam logic [7:0]  LEAD4         = 8'hF0;
  localparam logic [7:0]  LEAD3         = 8'hE0;
  localparam logic [7:0]  LEAD2         = 8'hC0;
  localparam logic [7:0]  CONT          = 8'h80;
  localparam logic [7:0]  REPL_CHAR     = 8'h3F;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one classified item: up to four bytes, first in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
  } u16u8_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u16u8_qstat_t;

endpackage
`default_nettype wire

// ===== src/utf16le_to_utf8_stream.sv =====
// UTF-16 to UTF-8 stream converter.
// Input channel: in_push / in_full with in_code_unit (one 16-bit unit) and
// in_string_last (marks the final unit of a string). An item is taken at a
// clock edge with in_push high and in_full low.
// Output channel: out_empty / out_pop. While out_empty is low the oldest
// byte sits on out_utf8_byte with out_run_end (last byte of its item) and
// out_string_end (last byte of a string); out_pop high takes it.
// A unit gives 1..4 bytes; a high surrogate gives none until its partner
// arrives, and an unpaired one turns into 0x3F.
// An item goes via the queue into the serializer register, where its first
// byte shows. Throughput: one item per cycle in, one byte per cycle out;
// sustained item rate is one per cycle for ASCII, one per N output bytes
// for N-byte characters, set by the single-byte serializer. A four-entry
// queue between classifier and serializer absorbs bursts, so items keep
// flowing while the receiver stalls until it fills; then in_full rises.
// Reset drops any held surrogate, empties the queue and the serializer.
`timescale 1ns / 1ps
`default_nettype none
module utf16le_to_utf8_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_string_last,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_utf8_byte,
  output logic             out_run_end,
  output logic             out_string_end
);

  u16u8_pkg::u16u8_qstat_t q_stat;
  u16u8_pkg::u16u8_entry_t wr_entry, rd_entry;
  logic                    q_push, q_pop;

  // classifier
  u16u8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_code_unit   (in_code_unit),
    .in_string_last (in_string_last),
    .in_full        (in_full),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_entry        (wr_entry)
  );

  // decoupling queue
  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  // byte serializer
  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_entry        (rd_entry),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_utf8_byte  (out_utf8_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue underflow");

  // string end only on the last byte of an item
  a_str_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_string_end) |-> out_run_end)
    else $error("string end without run end");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

endmodule
`default_nettype wire

// ===== src/u16u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_push,
  input  wire logic [15:0]             in_code_unit,
  input  wire logic                    in_string_last,
  output logic                         in_full,
  input  wire u16u8_pkg::u16u8_qstat_t q_stat,
  output logic                         q_push,
  output u16u8_pkg::u16u8_entry_t      q_entry
);

  logic        pend_r, pend_nxt;
  logic [9:0]  hb_r, hb_nxt;
  logic        accept;
  logic        is_high, is_low;
  logic [10:0] cp_hi;
  logic [20:0] cp;
  logic [2:0]  n;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  // classify the unit
  assign is_high = (in_code_unit >= u16u8_pkg::SURR_HIGH_MIN) &&
                   (in_code_unit <= u16u8_pkg::SURR_HIGH_MAX);
  assign is_low  = (in_code_unit >= u16u8_pkg::SURR_LOW_MIN) &&
                   (in_code_unit <= u16u8_pkg::SURR_LOW_MAX);

  // supplementary code point from the held high half
  assign cp_hi = {1'b0, hb_r} + u16u8_pkg::PLANE_OFFSET;
  assign cp    = {cp_hi, in_code_unit[9:0]};

  // build the byte list for this unit
  always_comb begin
    q_entry       = '0;
    q_entry.last  = in_string_last;
    n             = 3'd0;
    if (pend_r && is_low) begin
      q_entry.bytes[0] = u16u8_pkg::LEAD4 | {5'd0, cp[20:18]};
      q_entry.bytes[1] = u16u8_pkg::CONT | {2'd0, cp[17:12]};
      q_entry.bytes[2] = u16u8_pkg::CONT | {2'd0, cp[11:6]};
      q_entry.bytes[3] = u16u8_pkg::CONT | {2'd0, cp[5:0]};
      n = 3'd4;
    end else begin
      // unpaired high surrogate held before
      if (pend_r) begin
        q_entry.bytes[0] = u16u8_pkg::REPL_CHAR;
        n = 3'd1;
      end
      if (is_high) begin
        if (in_string_last) begin
          q_entry.bytes[n[1:0]] = u16u8_pkg::REPL_CHAR;
          n = n + 3'd1;
        end
      end else if (in_code_unit < u16u8_pkg::ONE_BYTE_LIM) begin
        q_entry.bytes[n[1:0]] = in_code_unit[7:0];
        n = n + 3'd1;
      end else if (in_code_unit < u16u8_pkg::TWO_BYTE_LIM) begin
        q_entry.bytes[n[1:0]] = u16u8_pkg::LEAD2 | {3'd0, in_code_unit[10:6]};
        n = n + 3'd1;
        q_entry.bytes[n[1:0]] = u16u8_pkg::CONT | {2'd0, in_code_unit[5:0]};
        n = n + 3'd1;
      end else begin
        q_entry.bytes[n[1:0]] = u16u8_pkg::LEAD3 | {4'd0, in_code_unit[15:12]};
        n = n + 3'd1;
        q_entry.bytes[n[1:0]] = u16u8_pkg::CONT | {2'd0, in_code_unit[11:6]};
        n = n + 3'd1;
        q_entry.bytes[n[1:0]] = u16u8_pkg::CONT | {2'd0, in_code_unit[5:0]};
        n = n + 3'd1;
      end
    end
    q_entry.cnt = n;
  end

  // items that only park a high surrogate push nothing
  assign q_push = accept && (n != 3'd0);

  // surrogate holding state
  always_comb begin
    pend_nxt = pend_r;
    hb_nxt   = hb_r;
    if (accept) begin
      if (is_high && !(pend_r && is_low) && !in_string_last) begin
        pend_nxt = 1'b1;
        hb_nxt   = in_code_unit[9:0];
      end else begin
        pend_nxt = 1'b0;
        hb_nxt   = 10'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hb_r   <= 10'd0;
    end else begin
      pend_r <= pend_nxt;
      hb_r   <= hb_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/u16u8_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u16u8_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire u16u8_pkg::u16u8_entry_t wr_entry,
  input  wire logic                    pop,
  output u16u8_pkg::u16u8_entry_t      rd_entry,
  output u16u8_pkg::u16u8_qstat_t      stat
);

  u16u8_pkg::u16u8_entry_t          mem_r [u16u8_pkg::QDEPTH];
  logic [u16u8_pkg::QAW-1:0]        wp_r, rp_r;
  logic [u16u8_pkg::QAW:0]          cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign stat.full  = (cnt_r == (u16u8_pkg::QAW+1)'(u16u8_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_entry   = mem_r[rp_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ===== src/u16u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire u16u8_pkg::u16u8_qstat_t q_stat,
  input  wire u16u8_pkg::u16u8_entry_t q_entry,
  output logic                         q_pop,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output logic [7:0]                   out_utf8_byte,
  output logic                         out_run_end,
  output logic                         out_string_end
);

  logic            vld_r;
  logic [3:0][7:0] bytes_r;
  logic [2:0]      rem_r;
  logic            last_r;
  logic            take, done, load;

  // current byte is always slot 0
  assign out_empty      = !vld_r;
  assign out_utf8_byte  = bytes_r[0];
  assign out_run_end    = (rem_r == 3'd1);
  assign out_string_end = out_run_end && last_r;

  assign take  = out_pop && vld_r;
  assign done  = take && (rem_r == 3'd1);
  assign load  = !vld_r || done;
  assign q_pop = load && !q_stat.empty;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 3'd0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      rem_r <= q_entry.cnt;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (take) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  // byte shifter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      bytes_r <= q_entry.bytes;
      last_r  <= q_entry.last;
    end else if (take) begin
      bytes_r <= {8'd0, bytes_r[3:1]};
    end
  end

endmodule
`default_nettype wire

// ===== bench/utf8_byte_checker.sv =====
`timescale 1ns / 1ps
module utf8_byte_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        in_full,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_string_last,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [7:0]  out_utf8_byte,
  input  wire logic        out_run_end,
  input  wire logic        out_string_end,
  output int               fail_count,
  output int               pending_bytes,
  output int               units_taken,
  output int               bytes_taken,
  output int               pairs_seen,
  output int               repl_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } utf8_out_t;

  localparam int RING_DEPTH = 256;

  // bytes still owed by the block, oldest first
  utf8_out_t exp_ring [RING_DEPTH];
  int        wr_idx = 0;
  int        rd_idx = 0;

  // predictor copy of the held high surrogate
  logic       held_valid = 1'b0;
  logic [9:0] held_bits  = '0;

  int errors   = 0;
  int units    = 0;
  int bytes    = 0;
  int pairs    = 0;
  int repls    = 0;
  utf8_out_t got;
  utf8_out_t want;

  assign fail_count    = errors;
  assign pending_bytes = wr_idx - rd_idx;
  assign units_taken   = units;
  assign bytes_taken   = bytes;
  assign pairs_seen    = pairs;
  assign repl_seen     = repls;

  // append one owed byte
  task automatic owe_byte(input logic [7:0] data, input logic run_end,
                          input logic string_end);
    exp_ring[wr_idx % RING_DEPTH] = '{data, run_end, string_end};
    wr_idx++;
  endtask

  // predict the utf-8 bytes one code unit produces
  task automatic transcode_unit(input logic [15:0] unit, input logic last);
    logic            is_high;
    logic            is_low;
    logic            paired;
    logic [20:0]     cp;
    logic [15:0]     offset;
    logic [3:0][7:0] burst;
    int              nb;
    is_high = unit >= u16u8_pkg::SURR_HIGH_MIN && unit <= u16u8_pkg::SURR_HIGH_MAX;
    is_low  = unit >= u16u8_pkg::SURR_LOW_MIN && unit <= u16u8_pkg::SURR_LOW_MAX;
    paired  = 1'b0;
    burst   = '0;
    nb      = 0;

    // a held high surrogate either pairs up or turns into '?'
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_low) begin
        offset = unit - u16u8_pkg::SURR_LOW_MIN;
        cp = 21'h10000 + {1'b0, held_bits, 10'b0} + {5'b0, offset};
        burst[0] = u16u8_pkg::LEAD4 | {5'b0, cp[20:18]};
        burst[1] = u16u8_pkg::CONT | {2'b0, cp[17:12]};
        burst[2] = u16u8_pkg::CONT | {2'b0, cp[11:6]};
        burst[3] = u16u8_pkg::CONT | {2'b0, cp[5:0]};
        nb = 4;
        paired = 1'b1;
        pairs++;
      end else begin
        burst[nb] = u16u8_pkg::REPL_CHAR;
        nb++;
        repls++;
      end
      held_bits = '0;
    end

    if (!paired) begin
      if (is_high) begin
        if (last) begin
          burst[nb] = u16u8_pkg::REPL_CHAR;
          nb++;
          repls++;
        end else begin
          offset     = unit - u16u8_pkg::SURR_HIGH_MIN;
          held_valid = 1'b1;
          held_bits  = offset[9:0];
        end
      end else if (unit < u16u8_pkg::ONE_BYTE_LIM) begin
        burst[nb] = unit[7:0];
        nb++;
      end else if (unit < u16u8_pkg::TWO_BYTE_LIM) begin
        burst[nb] = u16u8_pkg::LEAD2 | {3'b0, unit[10:6]};
        nb++;
        burst[nb] = u16u8_pkg::CONT | {2'b0, unit[5:0]};
        nb++;
      end else begin
        // lone low surrogates land here too
        burst[nb] = u16u8_pkg::LEAD3 | {4'b0, unit[15:12]};
        nb++;
        burst[nb] = u16u8_pkg::CONT | {2'b0, unit[11:6]};
        nb++;
        burst[nb] = u16u8_pkg::CONT | {2'b0, unit[5:0]};
        nb++;
      end
    end

    // flags only on the final byte of this unit
    for (int i = 0; i < nb; i++) begin
      owe_byte(burst[i], i == nb - 1, (i == nb - 1) && last);
    end
  endtask

  // compare each taken byte, then predict for each taken unit
  always @(posedge clk) begin
    if (!rst_n) begin
      wr_idx     = 0;
      rd_idx     = 0;
      held_valid = 1'b0;
      held_bits  = '0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{out_utf8_byte, out_run_end, out_string_end};
        bytes++;
        if (wr_idx == rd_idx) begin
          errors++;
          $display("%0t: unexpected byte %02h run_end %0b string_end %0b", $time,
                   got.data, got.run_end, got.string_end);
        end else begin
          want = exp_ring[rd_idx % RING_DEPTH];
          rd_idx++;
          if (got.data !== want.data) begin
            errors++;
            $display("%0t: utf8_byte expected %02h actual %02h", $time, want.data, got.data);
          end
          if (got.run_end !== want.run_end) begin
            errors++;
            $display("%0t: run_end expected %0b actual %0b", $time,
                     want.run_end, got.run_end);
          end
          if (got.string_end !== want.string_end) begin
            errors++;
            $display("%0t: string_end expected %0b actual %0b", $time,
                     want.string_end, got.string_end);
          end
        end
      end
      if (in_push && !in_full) begin
        units++;
        transcode_unit(in_code_unit, in_string_last);
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int RANDOM_UNITS   = 136;
  localparam int CALM_TAIL      = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_push        = 1'b0;
  logic        in_full;
  logic [15:0] in_code_unit   = '0;
  logic        in_string_last = 1'b0;
  logic        out_empty;
  logic        out_pop        = 1'b0;
  logic [7:0]  out_utf8_byte;
  logic        out_run_end;
  logic        out_string_end;

  int fail_count;
  int pending_bytes;
  int units_taken;
  int bytes_taken;
  int pairs_seen;
  int repl_seen;

  bit calm        = 1'b0;
  int pop_stall   = 0;
  int quiet_count = 0;
  int units_sent  = 0;

  // {string_last, code_unit}
  logic [16:0] directed [24] = '{
    17'h0_0000, 17'h0_007F, 17'h0_0080, 17'h0_07FF, 17'h0_0800, 17'h0_D7FF,
    17'h0_E000, 17'h1_FFFF,
    17'h0_D800, 17'h0_DC00, 17'h0_DBFF, 17'h1_DFFF,
    17'h0_DC00, 17'h0_DFFF,
    17'h0_D800, 17'h0_0041,
    17'h0_D801, 17'h0_DBFE, 17'h0_DC01,
    17'h1_DA00,
    17'h0_D900, 17'h1_DB00,
    17'h0_D8AA, 17'h1_007F
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  utf16le_to_utf8_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_code_unit   (in_code_unit),
    .in_string_last (in_string_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_utf8_byte  (out_utf8_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

  utf8_byte_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_code_unit   (in_code_unit),
    .in_string_last (in_string_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_utf8_byte  (out_utf8_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end),
    .fail_count     (fail_count),
    .pending_bytes  (pending_bytes),
    .units_taken    (units_taken),
    .bytes_taken    (bytes_taken),
    .pairs_seen     (pairs_seen),
    .repl_seen      (repl_seen)
  );

  // receiver stalls at random in bursts, except once calm is set
  always @(negedge clk) begin
    if (pop_stall > 0) begin
      out_pop   <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_pop   <= 1'b0;
      pop_stall <= int'($urandom_range(0, 2));
    end else begin
      out_pop <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("utf16le_to_utf8_stream test failed");
      $finish;
    end
  end

  // hold one item until it is taken; push stays high afterwards
  task automatic send_unit(input logic [15:0] unit, input logic last);
    in_push        <= 1'b1;
    in_code_unit   <= unit;
    in_string_last <= last;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    units_sent++;
  endtask

  task automatic hold_sender(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) hold_sender(int'($urandom_range(1, 3)));
  endtask

  // one random character: one unit, or two for a surrogate pair
  task automatic send_char(input logic last);
    int          pick;
    logic [15:0] unit;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) begin
      unit = 16'($urandom_range(0, 16'h007F));
    end else if (pick < 45) begin
      unit = 16'($urandom_range(16'h0080, 16'h07FF));
    end else if (pick < 60) begin
      unit = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                  : 16'($urandom_range(16'hE000, 16'hFFFF));
    end else if (pick < 80) begin
      send_unit(16'($urandom_range(u16u8_pkg::SURR_HIGH_MIN, u16u8_pkg::SURR_HIGH_MAX)),
                1'b0);
      maybe_gap();
      unit = 16'($urandom_range(u16u8_pkg::SURR_LOW_MIN, u16u8_pkg::SURR_LOW_MAX));
    end else if (pick < 87) begin
      unit = 16'($urandom_range(u16u8_pkg::SURR_HIGH_MIN, u16u8_pkg::SURR_HIGH_MAX));
    end else if (pick < 92) begin
      unit = 16'($urandom_range(u16u8_pkg::SURR_LOW_MIN, u16u8_pkg::SURR_LOW_MAX));
    end else begin
      unit = 16'($urandom_range(0, 16'hFFFF));
    end
    send_unit(unit, last);
  endtask

  initial begin
    int  target;
    int  str_len;
    bit  paused;
    paused = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // range edges, pairs, lone and trailing surrogates
    foreach (directed[i]) begin
      send_unit(directed[i][15:0], directed[i][16]);
      maybe_gap();
    end

    // random strings of 1 to 8 characters
    target = units_sent + RANDOM_UNITS;
    while (units_sent < target) begin
      str_len = int'($urandom_range(1, 8));
      for (int c = 0; c < str_len; c++) begin
        send_char(c == str_len - 1);
        maybe_gap();
      end
      if (!paused && units_sent >= target - RANDOM_UNITS / 2) begin
        paused = 1'b1;
        hold_sender(1);
        while (pending_bytes != 0) @(negedge clk);
      end
      if (units_sent >= target - CALM_TAIL) calm <= 1'b1;
    end
    hold_sender(1);

    while (pending_bytes != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run took %0d code units and checked %0d utf-8 bytes", units_taken, bytes_taken);
    $display("including %0d surrogate pairs and %0d replacement bytes", pairs_seen, repl_seen);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("utf16le_to_utf8_stream test passed");
    end else begin
      $display("utf16le_to_utf8_stream test failed");
    end
    $finish;
  end

endmodule
